[rtl/core/speed_command_line_parser_assert.svh]
// Assertion macros for the speed command line parser.
// Included by the top level; needs no package.
`ifndef SPEED_COMMAND_LINE_PARSER_ASSERT_SVH
`define SPEED_COMMAND_LINE_PARSER_ASSERT_SVH

// Condition at this edge implies consequence at this edge.
`define SCL_ASSERT_SAME(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Condition at this edge implies consequence at the next edge.
`define SCL_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

[rtl/core/scl_pkg.sv]
// Shared types, codes and character tables of the speed command line parser.
// No dependencies.
package scl_pkg;

    // Reply codes
    localparam logic [2:0] REPLY_NONE     = 3'd0;
    localparam logic [2:0] REPLY_ACCEPTED = 3'd1;
    localparam logic [2:0] REPLY_REJECTED = 3'd2;
    localparam logic [2:0] REPLY_UNHALTED = 3'd3;
    localparam logic [2:0] REPLY_HALTED   = 3'd4;

    // Register indexes
    localparam logic REG_IDLE_SPEED  = 1'b0;
    localparam logic REG_SPEED_LIMIT = 1'b1;

    localparam logic [15:0] IDLE_SPEED_RST  = 16'd600;
    localparam logic [15:0] SPEED_LIMIT_RST = 16'd10000;

    // Parser phases; phases 0 to 6 walk the prefix
    localparam logic [3:0] PH_PRE0  = 4'd0;
    localparam logic [3:0] PH_PRE6  = 4'd6;
    localparam logic [3:0] PH_NUM1  = 4'd7;
    localparam logic [3:0] PH_SIGN1 = 4'd8;
    localparam logic [3:0] PH_DIG1  = 4'd9;
    localparam logic [3:0] PH_NUM2  = 4'd10;
    localparam logic [3:0] PH_SIGN2 = 4'd11;
    localparam logic [3:0] PH_DIG2  = 4'd12;
    localparam logic [3:0] PH_DONE  = 4'd13;
    localparam logic [3:0] PH_FAIL  = 4'd15;

    localparam logic [16:0] ACC_MAX = 17'h1FFFF;

    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_BAR   = 8'h7C;
    localparam logic [7:0] CHAR_U     = 8'h55;

    localparam logic [2:0] UNHALT_LEN = 3'd6;

    // One classified request as it waits in the queue.
    typedef struct packed {
        logic       is_edge;
        logic       is_newline;
        logic       is_space;
        logic       is_digit;
        logic       is_sign;
        logic       is_minus;
        logic       is_bar;
        logic [3:0] digit;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic        halted;
        logic        direction_level;
        logic [15:0] speed_command;
        logic [2:0]  reply;
    } t_result;

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h41; // A
            3'd1:    c = 8'h4E; // N
            3'd2:    c = 8'h54; // T
            3'd3:    c = 8'h53; // S
            3'd4:    c = 8'h5F; // _
            3'd5:    c = 8'h53; // S
            default: c = 8'h7C; // |
        endcase
        return c;
    endfunction

    function automatic logic [7:0] unhalt_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h55; // U
            3'd1:    c = 8'h4E; // N
            3'd2:    c = 8'h48; // H
            3'd3:    c = 8'h41; // A
            3'd4:    c = 8'h4C; // L
            default: c = 8'h54; // T
        endcase
        return c;
    endfunction

endpackage

[rtl/core/speed_command_line_parser.sv]
// Speed command line parser: one request (serial byte or direction edge) in,
// one result out. An accepted request is held in the classifier queue, then
// executed by the back end into its result register. Throughput is one
// request per cycle unless the result output stalls, set by the parser step
// in the back end. Synchronous active-low reset clears the parser and
// queue, sets the speed to 600 and restores both registers to defaults.
`include "speed_command_line_parser_assert.svh"

module speed_command_line_parser #(
    parameter int CHECK_POS = 16,
    parameter int LINE_MAX  = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  i_s_axis_tuser,   // [0] func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [2:0] reply, [18:3] speed_command, [19] direction_level, [20] halted
    output logic [23:0] o_m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import scl_pkg::*;

    logic [15:0] r_idle_speed;
    logic [15:0] r_speed_limit;
    logic        w_cfg_wr;
    logic        w_q_valid;
    t_item       w_q_item;
    logic        w_take;
    t_result     w_result;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_speed  <= IDLE_SPEED_RST;
            r_speed_limit <= SPEED_LIMIT_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_IDLE_SPEED:  r_idle_speed  <= pwdata[15:0];
                REG_SPEED_LIMIT: r_speed_limit <= pwdata[15:0];
                default:         r_idle_speed  <= r_idle_speed;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_IDLE_SPEED:  prdata = {16'd0, r_idle_speed};
            REG_SPEED_LIMIT: prdata = {16'd0, r_speed_limit};
            default:         prdata = 32'd0;
        endcase
    end

    scl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_func  (i_s_axis_tuser[0]),
        .i_byte  (i_s_axis_tdata),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_take)
    );

    scl_back #(
        .CHECK_POS (CHECK_POS),
        .LINE_MAX  (LINE_MAX)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_q_valid),
        .i_item        (w_q_item),
        .o_pop         (w_take),
        .i_idle_speed  (r_idle_speed),
        .i_speed_limit (r_speed_limit),
        .o_valid       (o_m_axis_tvalid),
        .o_result      (w_result),
        .i_ready       (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {3'b000, w_result.halted, w_result.direction_level,
                             w_result.speed_command, w_result.reply};

    // The back end only pops a queued request, and every pop yields a result.
    `SCL_ASSERT_SAME(a_take_needs_item, i_clk, i_rst_n, w_take, w_q_valid, "pop from empty queue")
    `SCL_ASSERT_NEXT(a_take_gives_result, i_clk, i_rst_n, w_take, o_m_axis_tvalid, "pop without result")
    `SCL_ASSERT_SAME(a_halt_reply_flag, i_clk, i_rst_n, o_m_axis_tvalid && (w_result.reply == REPLY_HALTED), w_result.halted, "halt reply while not halted")
    `SCL_ASSERT_SAME(a_run_reply_flag, i_clk, i_rst_n, o_m_axis_tvalid && ((w_result.reply == REPLY_UNHALTED) || (w_result.reply == REPLY_ACCEPTED)), !w_result.halted, "run reply while halted")

endmodule

[rtl/core/scl_front.sv]
// Front end: accepts requests, classifies each byte and holds it in a
// two-entry queue for the back end. Depends on scl_pkg.
module scl_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_func,
    input  logic [7:0]    i_byte,
    output logic          o_valid,
    output scl_pkg::t_item o_item,
    input  logic          i_pop
);
    import scl_pkg::*;

    t_item       r_q [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count, n_count;
    t_item       w_class;
    logic        w_push;

    always_comb begin
        w_class.is_edge    = i_func;
        w_class.is_newline = (i_byte == CHAR_NL);
        w_class.is_space   = (i_byte == CHAR_SPACE) || (i_byte == CHAR_TAB) ||
                             (i_byte == CHAR_CR) || (i_byte == CHAR_VT) ||
                             (i_byte == CHAR_FF);
        w_class.is_digit   = (i_byte >= CHAR_ZERO) && (i_byte <= CHAR_NINE);
        w_class.is_sign    = (i_byte == CHAR_PLUS) || (i_byte == CHAR_MINUS);
        w_class.is_minus   = (i_byte == CHAR_MINUS);
        w_class.is_bar     = (i_byte == CHAR_BAR);
        w_class.digit      = 4'(i_byte - CHAR_ZERO);
        w_class.data       = i_byte;
    end

    assign o_ready = (r_count != 2'd2);
    assign w_push  = i_valid && o_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ w_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + 2'(w_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_class;
        end
    end

endmodule

[rtl/core/scl_back.sv]
// Back end: runs the line parser, checksum, halt logic and speed update for
// each classified request, and holds the result register. Depends on scl_pkg.
module scl_back #(
    parameter int CHECK_POS = 16,
    parameter int LINE_MAX  = 24
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  scl_pkg::t_item  i_item,
    output logic            o_pop,
    input  logic [15:0]     i_idle_speed,
    input  logic [15:0]     i_speed_limit,
    output logic            o_valid,
    output scl_pkg::t_result o_result,
    input  logic            i_ready
);
    import scl_pkg::*;

    localparam int PW = $clog2(LINE_MAX);
    localparam logic [PW-1:0] CHK_POS  = PW'(CHECK_POS);
    localparam logic [PW-1:0] LAST_POS = PW'(LINE_MAX - 1);

    logic [PW-1:0] r_pos,       n_pos;
    logic [7:0]    r_xor,       n_xor;
    logic [7:0]    r_check,     n_check;
    logic [3:0]    r_phase,     n_phase;
    logic [16:0]   r_acc,       n_acc;
    logic          r_neg,       n_neg;
    logic [15:0]   r_pend_spd,  n_pend_spd;
    logic [7:0]    r_pend_dir,  n_pend_dir;
    logic [2:0]    r_umatch,    n_umatch;
    logic          r_line_bad,  n_line_bad;
    logic          r_halt,      n_halt;
    logic [15:0]   r_speed,     n_speed;
    logic [7:0]    r_dir_val,   n_dir_val;
    logic          r_dir_out,   n_dir_out;
    logic          r_out_valid, n_out_valid;
    t_result       r_out,       n_out;

    logic          w_take;
    logic [20:0]   w_acc_x10;
    logic [16:0]   w_acc_next;
    logic [7:0]    w_fin_dir;
    logic [15:0]   w_fin_spd;
    logic [7:0]    w_line_dir;
    logic [7:0]    w_expect;
    logic [2:0]    w_reply;
    logic          w_parsed;

    assign w_take = i_valid && (!r_out_valid || i_ready);
    assign o_pop  = w_take;

    // Times ten as two shifts and an add, saturated.
    always_comb begin
        w_acc_x10  = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + 21'(i_item.digit);
        w_acc_next = (w_acc_x10 > 21'(ACC_MAX)) ? ACC_MAX : w_acc_x10[16:0];
    end

    always_comb begin
        if (r_neg) begin
            w_fin_dir = (r_acc > 17'd128) ? 8'h80 : 8'(~r_acc[7:0] + 8'd1);
        end else begin
            w_fin_dir = (r_acc > 17'd127) ? 8'h7F : r_acc[7:0];
        end
        if (r_neg) begin
            w_fin_spd = 16'd0;
        end else if (r_acc > {1'b0, i_speed_limit}) begin
            w_fin_spd = i_speed_limit;
        end else begin
            w_fin_spd = r_acc[15:0];
        end
    end

    assign w_parsed   = (r_phase == PH_DIG2) || (r_phase == PH_DONE);
    assign w_line_dir = (r_phase == PH_DIG2) ? w_fin_dir : r_pend_dir;
    assign w_expect   = r_dir_out ? 8'h01 : 8'hFF;

    always_comb begin
        n_pos      = r_pos;
        n_xor      = r_xor;
        n_check    = r_check;
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_neg      = r_neg;
        n_pend_spd = r_pend_spd;
        n_pend_dir = r_pend_dir;
        n_umatch   = r_umatch;
        n_line_bad = r_line_bad;
        n_halt     = r_halt;
        n_speed    = r_speed;
        n_dir_val  = r_dir_val;
        n_dir_out  = r_dir_out;
        w_reply    = REPLY_NONE;

        if (i_item.is_edge) begin
            if (r_dir_val != w_expect) begin
                n_speed = i_idle_speed;
                n_halt  = 1'b1;
                w_reply = REPLY_HALTED;
            end
        end else if (i_item.is_newline) begin
            if (r_halt) begin
                if (r_umatch >= UNHALT_LEN) begin
                    n_halt  = 1'b0;
                    n_speed = i_idle_speed;
                    w_reply = REPLY_UNHALTED;
                end
            end else if (!r_line_bad && (r_pos > CHK_POS) && w_parsed &&
                         (r_check == r_xor)) begin
                n_speed   = r_pend_spd;
                n_dir_val = w_line_dir;
                n_dir_out = !w_line_dir[7];
                w_reply   = REPLY_ACCEPTED;
            end else begin
                w_reply = REPLY_REJECTED;
            end
            n_pos      = '0;
            n_xor      = 8'd0;
            n_check    = 8'd0;
            n_phase    = PH_PRE0;
            n_acc      = 17'd0;
            n_neg      = 1'b0;
            n_pend_spd = 16'd0;
            n_pend_dir = 8'd0;
            n_umatch   = 3'd0;
            n_line_bad = 1'b0;
        end else begin
            if (r_pos < CHK_POS) begin
                n_xor = r_xor ^ i_item.data;
            end else if (r_pos == CHK_POS) begin
                n_check = i_item.data;
            end
            if (r_pos < LAST_POS) begin
                n_pos = r_pos + 1'b1;
            end else begin
                n_line_bad = 1'b1;
            end

            unique case (r_phase) inside
                [PH_PRE0:PH_PRE6]: begin
                    n_phase = (i_item.data == prefix_char(r_phase[2:0])) ?
                              r_phase + 4'd1 : PH_FAIL;
                end
                PH_NUM1, PH_NUM2: begin
                    if (i_item.is_space) begin
                        n_phase = r_phase;
                    end else if (i_item.is_sign) begin
                        n_neg   = i_item.is_minus;
                        n_phase = r_phase + 4'd1;
                    end else if (i_item.is_digit) begin
                        n_acc   = w_acc_next;
                        n_phase = r_phase + 4'd2;
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end
                PH_SIGN1, PH_SIGN2: begin
                    if (i_item.is_digit) begin
                        n_acc   = w_acc_next;
                        n_phase = r_phase + 4'd1;
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end
                PH_DIG1: begin
                    if (i_item.is_digit) begin
                        n_acc = w_acc_next;
                    end else if (i_item.is_bar) begin
                        n_pend_spd = w_fin_spd;
                        n_acc      = 17'd0;
                        n_neg      = 1'b0;
                        n_phase    = PH_NUM2;
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end
                PH_DIG2: begin
                    if (i_item.is_digit) begin
                        n_acc = w_acc_next;
                    end else begin
                        n_pend_dir = w_fin_dir;
                        n_phase    = PH_DONE;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase

            // Watch for the unhalt word anywhere in the line.
            if (r_umatch < UNHALT_LEN) begin
                if (i_item.data == unhalt_char(r_umatch)) begin
                    n_umatch = r_umatch + 3'd1;
                end else begin
                    n_umatch = (i_item.data == CHAR_U) ? 3'd1 : 3'd0;
                end
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_take) begin
            n_out_valid           = 1'b1;
            n_out.reply           = w_reply;
            n_out.speed_command   = n_speed;
            n_out.direction_level = n_dir_out;
            n_out.halted          = n_halt;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_xor       <= 8'd0;
            r_check     <= 8'd0;
            r_phase     <= PH_PRE0;
            r_acc       <= 17'd0;
            r_neg       <= 1'b0;
            r_pend_spd  <= 16'd0;
            r_pend_dir  <= 8'd0;
            r_umatch    <= 3'd0;
            r_line_bad  <= 1'b0;
            r_halt      <= 1'b0;
            r_speed     <= IDLE_SPEED_RST;
            r_dir_val   <= 8'd1;
            r_dir_out   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_take) begin
                r_pos      <= n_pos;
                r_xor      <= n_xor;
                r_check    <= n_check;
                r_phase    <= n_phase;
                r_acc      <= n_acc;
                r_neg      <= n_neg;
                r_pend_spd <= n_pend_spd;
                r_pend_dir <= n_pend_dir;
                r_umatch   <= n_umatch;
                r_line_bad <= n_line_bad;
                r_halt     <= n_halt;
                r_speed    <= n_speed;
                r_dir_val  <= n_dir_val;
                r_dir_out  <= n_dir_out;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

[tb/speed_command_line_parser_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for speed_command_line_parser: serial command lines and direction
// pin events go in on the stream slave, each reply is checked against a local parser model.
// Depends on scl_pkg and the block's RTL.
module speed_command_line_parser_test;
    import scl_pkg::*;

    localparam int CHECK_POS       = 16;
    localparam int LINE_MAX        = 24;
    localparam int RUN_LIMIT       = 300000;
    localparam int ITEMS_PER_PHASE = 320;
    localparam int SETTLE_CYCLES   = 4;
    localparam int SHOWN_ERRORS    = 10;

    localparam logic [7:0] LINE_LEAD [7] = '{8'h41, 8'h4E, 8'h54, 8'h53, 8'h5F, 8'h53, 8'h7C};
    localparam logic [7:0] UNHALT_WORD [6] = '{8'h55, 8'h4E, 8'h48, 8'h41, 8'h4C, 8'h54};

    typedef struct packed {
        logic       pin_edge;
        logic [7:0] rx;
    } t_link_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'h00;     // [7:0] rx_byte
    logic [0:0]  i_s_axis_tuser = 1'b0;      // [0] func
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b1;
    // [2:0] reply, [18:3] speed_command, [19] direction_level, [20] halted
    logic [23:0] o_m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    speed_command_line_parser #(
        .CHECK_POS(CHECK_POS),
        .LINE_MAX (LINE_MAX)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_link_event pending_requests[$];
    t_result     expected_replies[$];
    logic [7:0]  line_text[$];
    int          queued_count = 0;
    int          accepted_count = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          edge_mix_pct = 0;
    logic        req_taken = 1'b0;

    // Model of the block: configuration, line under way, and motor state.
    logic [15:0] cfg_idle;
    logic [15:0] cfg_limit;
    logic [4:0]  ln_pos;
    logic [7:0]  ln_xor;
    logic [7:0]  ln_check;
    logic [3:0]  ln_phase;
    logic [16:0] ln_acc;
    logic        ln_neg;
    logic [15:0] ln_speed;
    logic [7:0]  ln_dir;
    logic [2:0]  ln_unhalt;
    logic        ln_bad;
    logic        m_halted;
    logic [15:0] m_speed;
    logic [7:0]  m_dir;
    logic        m_dir_out;

    function automatic void clear_line();
        ln_pos = '0;
        ln_xor = '0;
        ln_check = '0;
        ln_phase = PH_PRE0;
        ln_acc = '0;
        ln_neg = 1'b0;
        ln_speed = '0;
        ln_dir = '0;
        ln_unhalt = '0;
        ln_bad = 1'b0;
    endfunction

    function automatic void push_digit(input logic [7:0] ch);
        logic [31:0] v;
        v = 32'(ln_acc) * 32'd10 + 32'(ch - CHAR_ZERO);
        ln_acc = (v > 32'(ACC_MAX)) ? ACC_MAX : v[16:0];
    endfunction

    function automatic void close_direction();
        logic [16:0] m;
        m = ln_acc;
        if (ln_neg) begin
            if (m > 17'd128) m = 17'd128;
            ln_dir = 8'(9'd256 - 9'(m));
        end else begin
            if (m > 17'd127) m = 17'd127;
            ln_dir = m[7:0];
        end
    endfunction

    // Applies one accepted request to the model and returns the reply it must produce.
    function automatic t_result advance_line_parser(input logic pin, input logic [7:0] ch);
        t_result     r;
        logic [7:0]  want_dir;
        logic [3:0]  ph;
        logic [16:0] sp;
        logic        parsed;
        logic        blank;
        logic        digit;
        r.reply = REPLY_NONE;
        if (pin) begin
            want_dir = m_dir_out ? 8'h01 : 8'hFF;
            if (m_dir != want_dir) begin
                m_speed = cfg_idle;
                m_halted = 1'b1;
                r.reply = REPLY_HALTED;
            end
        end else if (ch == CHAR_NL) begin
            if (m_halted) begin
                if (ln_unhalt >= UNHALT_LEN) begin
                    m_halted = 1'b0;
                    m_speed = cfg_idle;
                    r.reply = REPLY_UNHALTED;
                end
            end else begin
                parsed = (ln_phase == PH_DIG2) || (ln_phase == PH_DONE);
                if (ln_phase == PH_DIG2) close_direction();
                if (!ln_bad && ln_pos > CHECK_POS && parsed && ln_check == ln_xor) begin
                    m_speed = ln_speed;
                    m_dir = ln_dir;
                    m_dir_out = !ln_dir[7];
                    r.reply = REPLY_ACCEPTED;
                end else begin
                    r.reply = REPLY_REJECTED;
                end
            end
            clear_line();
        end else begin
            if (ln_pos < CHECK_POS) ln_xor ^= ch;
            else if (ln_pos == CHECK_POS) ln_check = ch;
            if (ln_pos < LINE_MAX - 1) ln_pos = ln_pos + 5'd1;
            else ln_bad = 1'b1;

            blank = (ch == CHAR_SPACE) || (ch == CHAR_TAB) || (ch == CHAR_CR) ||
                    (ch == CHAR_VT) || (ch == CHAR_FF);
            digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
            ph = ln_phase;
            if (ph < PH_NUM1) begin
                ln_phase = (ch == LINE_LEAD[ph]) ? ph + 4'd1 : PH_FAIL;
            end else if (ph == PH_NUM1 || ph == PH_NUM2) begin
                if (blank) begin
                    ln_phase = ph;
                end else if (ch == CHAR_MINUS || ch == CHAR_PLUS) begin
                    ln_neg = (ch == CHAR_MINUS);
                    ln_phase = ph + 4'd1;
                end else if (digit) begin
                    push_digit(ch);
                    ln_phase = ph + 4'd2;
                end else begin
                    ln_phase = PH_FAIL;
                end
            end else if (ph == PH_SIGN1 || ph == PH_SIGN2) begin
                if (digit) begin
                    push_digit(ch);
                    ln_phase = ph + 4'd1;
                end else begin
                    ln_phase = PH_FAIL;
                end
            end else if (ph == PH_DIG1) begin
                if (digit) begin
                    push_digit(ch);
                end else if (ch == CHAR_BAR) begin
                    sp = ln_neg ? 17'd0 : ln_acc;
                    if (sp > {1'b0, cfg_limit}) sp = {1'b0, cfg_limit};
                    ln_speed = sp[15:0];
                    ln_acc = '0;
                    ln_neg = 1'b0;
                    ln_phase = PH_NUM2;
                end else begin
                    ln_phase = PH_FAIL;
                end
            end else if (ph == PH_DIG2) begin
                if (digit) begin
                    push_digit(ch);
                end else begin
                    close_direction();
                    ln_phase = PH_DONE;
                end
            end

            if (ln_unhalt < UNHALT_LEN) begin
                if (ch == UNHALT_WORD[ln_unhalt]) ln_unhalt = ln_unhalt + 3'd1;
                else ln_unhalt = (ch == CHAR_U) ? 3'd1 : 3'd0;
            end
        end
        r.speed_command = m_speed;
        r.direction_level = m_dir_out;
        r.halted = m_halted;
        return r;
    endfunction

    task automatic post_event(input logic pin, input logic [7:0] b);
        pending_requests.push_back(t_link_event'({pin, b}));
        queued_count++;
    endtask

    function automatic logic [7:0] fill_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CHAR_NL);
        return b;
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) line_text.push_back(s[i]);
    endtask

    task automatic start_command(input string speed_txt, input string dir_txt,
                                 input bit tail_bar);
        line_text.delete();
        for (int i = 0; i < 7; i++) line_text.push_back(LINE_LEAD[i]);
        add_text(speed_txt);
        line_text.push_back(CHAR_BAR);
        add_text(dir_txt);
        if (tail_bar) line_text.push_back(CHAR_BAR);
    endtask

    // Pads the body, inserts the check byte (optionally spoiled) and sends the line.
    task automatic send_line(input int total_len, input bit with_check,
                             input logic [7:0] check_flip);
        logic [7:0] sum;
        sum = 8'h00;
        if (with_check) begin
            while (line_text.size() < CHECK_POS) line_text.push_back(fill_byte());
            for (int i = 0; i < CHECK_POS; i++) sum ^= line_text[i];
            line_text.insert(CHECK_POS, sum ^ check_flip);
        end
        while (line_text.size() < total_len) line_text.push_back(fill_byte());
        while (line_text.size() > total_len) void'(line_text.pop_back());
        foreach (line_text[i]) begin
            // A pin event in the middle of a line must not disturb the line.
            if ($urandom_range(99) < edge_mix_pct) post_event(1'b1, 8'($urandom));
            post_event(1'b0, line_text[i]);
        end
        post_event(1'b0, CHAR_NL);
    endtask

    function automatic string signed_text(input int mag, input int sel);
        string s;
        s = $sformatf("%0d", mag);
        if (sel == 0) s = {"-", s};
        else if (sel == 1) s = {"+", s};
        return s;
    endfunction

    task automatic queue_random_line();
        int    kind;
        int    mag;
        string speed_txt;
        string dir_txt;
        kind = $urandom_range(99);
        if (kind < 8) begin
            post_event(1'b1, 8'($urandom));
        end else if (kind < 20) begin
            line_text.delete();
            repeat ($urandom_range(6))
                line_text.push_back(($urandom_range(2) == 0) ? CHAR_U : fill_byte());
            add_text(($urandom_range(9) == 0) ? "UNHALX" : "UNHALT");
            repeat ($urandom_range(6)) line_text.push_back(fill_byte());
            send_line(line_text.size(), 1'b0, 8'h00);
        end else if (kind < 28) begin
            line_text.delete();
            repeat ($urandom_range(30)) line_text.push_back(fill_byte());
            send_line(line_text.size(), 1'b0, 8'h00);
        end else begin
            case ($urandom_range(9))
                0:       mag = 0;
                1:       mag = int'(cfg_limit);
                2:       mag = int'(cfg_limit) + 1;
                3:       mag = $urandom_range(65536, 140000);
                default: mag = $urandom_range(int'(cfg_limit));
            endcase
            speed_txt = signed_text(mag, $urandom_range(7));
            case ($urandom_range(7))
                0:       speed_txt = {$sformatf("%c", CHAR_TAB), speed_txt};
                1:       speed_txt = {$sformatf("%c", CHAR_VT), speed_txt};
                2:       speed_txt = {$sformatf("%c", CHAR_FF), speed_txt};
                default: ;
            endcase
            case ($urandom_range(5))
                0:       dir_txt = "1";
                1:       dir_txt = "-1";
                2:       dir_txt = "+1";
                3:       dir_txt = signed_text($urandom_range(999), $urandom_range(2));
                default: dir_txt = signed_text($urandom_range(200), $urandom_range(2));
            endcase
            if ($urandom_range(9) == 0) dir_txt = {$sformatf("%c", CHAR_CR), dir_txt};
            start_command(speed_txt, dir_txt, $urandom_range(9) != 0);
            if ($urandom_range(19) == 0) line_text[$urandom_range(6)] = fill_byte();
            if (kind < 34)
                send_line($urandom_range(CHECK_POS), 1'b0, 8'h00);
            else if (kind < 40)
                send_line($urandom_range(LINE_MAX, LINE_MAX + 8), 1'b1, 8'h00);
            else if (kind < 47)
                send_line($urandom_range(CHECK_POS + 1, LINE_MAX - 1), 1'b1,
                          8'($urandom_range(1, 255)));
            else
                send_line($urandom_range(CHECK_POS + 1, LINE_MAX - 1), 1'b1, 8'h00);
        end
    endtask

    task automatic queue_directed();
        edge_mix_pct = 0;
        // Direction +1 with the level low after reset: the first pin event halts.
        post_event(1'b1, 8'h00);
        start_command("100", "1", 1'b1);
        send_line(CHECK_POS + 2, 1'b1, 8'h00);
        line_text.delete();
        add_text("xUUNHALT");
        send_line(line_text.size(), 1'b0, 8'h00);
        start_command("+70000", "-1", 1'b1);
        send_line(LINE_MAX - 1, 1'b1, 8'h00);
        post_event(1'b1, 8'hFF);
        start_command(" -5", "300", 1'b1);
        send_line(CHECK_POS + 1, 1'b1, 8'h00);
        start_command("200000", "-9", 1'b0);
        send_line(LINE_MAX - 1, 1'b1, 8'h00);
        line_text.delete();
        send_line(0, 1'b0, 8'h00);
        line_text.delete();
        repeat (LINE_MAX) line_text.push_back(8'hFF);
        send_line(LINE_MAX, 1'b0, 8'h00);
        line_text.delete();
        repeat (5) line_text.push_back(8'h00);
        send_line(5, 1'b0, 8'h00);
        start_command("50", "1", 1'b1);
        send_line(CHECK_POS + 1, 1'b1, 8'h01);
        post_event(1'b1, 8'h55);
    endtask

    task automatic write_register(input logic idx, input logic [15:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'h0000, val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_IDLE_SPEED) cfg_idle = val;
        else cfg_limit = val;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (accepted_count != queued_count || expected_replies.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Request driver: holds each request until it is taken.
    always @(negedge i_clk) begin
        t_link_event ev;
        if (i_rst_n) begin
            if (!i_s_axis_tvalid || req_taken) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    ev = pending_requests.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= ev.rx;
                    i_s_axis_tuser <= ev.pin_edge;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Reply monitor and request capture.
    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                seen = t_result'(o_m_axis_tdata[20:0]);
                if (expected_replies.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_ERRORS)
                        $display("reply with none outstanding: reply %0d speed %0d dir %0b halt %0b",
                                 seen.reply, seen.speed_command, seen.direction_level,
                                 seen.halted);
                end else begin
                    want = expected_replies.pop_front();
                    if (seen.reply != want.reply || seen.speed_command != want.speed_command ||
                        seen.direction_level != want.direction_level ||
                        seen.halted != want.halted) begin
                        mismatch_count++;
                        // Fields are reply, speed, direction level and halt flag.
                        if (mismatch_count <= SHOWN_ERRORS)
                            $display("reply mismatch: expected %0d %0d %0b %0b, got %0d %0d %0b %0b",
                                     want.reply, want.speed_command, want.direction_level,
                                     want.halted, seen.reply, seen.speed_command,
                                     seen.direction_level, seen.halted);
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_replies.push_back(advance_line_parser(i_s_axis_tuser[0],
                                                               i_s_axis_tdata));
                accepted_count++;
            end
            req_taken <= i_s_axis_tvalid && o_s_axis_tready;
        end
    end

    initial begin
        int start_count;
        cfg_idle = IDLE_SPEED_RST;
        cfg_limit = SPEED_LIMIT_RST;
        clear_line();
        m_halted = 1'b0;
        m_speed = IDLE_SPEED_RST;
        m_dir = 8'h01;
        m_dir_out = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: begin
                    write_register(REG_IDLE_SPEED, 16'd0);
                    write_register(REG_SPEED_LIMIT, 16'd1);
                end
                2: begin
                    write_register(REG_IDLE_SPEED, 16'hFFFF);
                    write_register(REG_SPEED_LIMIT, 16'hFFFF);
                end
                3: begin
                    write_register(REG_IDLE_SPEED, 16'($urandom_range(65535)));
                    write_register(REG_SPEED_LIMIT, 16'($urandom_range(1, 65535)));
                end
                4: begin
                    write_register(REG_IDLE_SPEED, 16'($urandom_range(65535)));
                    write_register(REG_SPEED_LIMIT, 16'($urandom_range(1, 400)));
                end
                default: ;
            endcase
            case (phase % 4)
                1:       begin send_idle_pct = 48; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 48; end
                3:       begin send_idle_pct = 28; stall_pct = 28; end
                default: begin send_idle_pct = 0;  stall_pct = 0;  end
            endcase
            if (phase == 0) queue_directed();
            edge_mix_pct = 2;
            start_count = queued_count;
            while (queued_count - start_count < ITEMS_PER_PHASE) queue_random_line();
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
